// ===== sv/ssh_pkg.sv =====
// ----------------------------------------------------------------------------
// ssh_pkg - shared types and constants of the stereo clip waveshaper
// sample format, register indexes, lane payload types and the arctangent rom
// ----------------------------------------------------------------------------
`default_nettype none

package ssh_pkg;

   // sample format: signed q1.23
   localparam int SAMPLE_W = 24;
   localparam int FRAC_W   = SAMPLE_W - 1;
   localparam int GAIN_W   = 24;
   localparam int BLEND_W  = 17;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLEND_AMOUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAKEUP_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MUTE_ENABLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BYPASS       = 3'd4;

   localparam logic [GAIN_W-1:0]  DRIVE_GAIN_RST  = 24'd65536;
   localparam logic [BLEND_W-1:0] BLEND_RST       = 17'd0;
   localparam logic [GAIN_W-1:0]  MAKEUP_GAIN_RST = 24'd65536;
   localparam logic [BLEND_W-1:0] BLEND_UNITY     = 17'd65536;

   // arctangent table: atan(k / depth) in q.23, k = 0 .. depth
   localparam int ATAN_DEPTH   = 256;
   localparam int ATAN_IDX_W   = 8;
   localparam int ATAN_ENTRIES = ATAN_DEPTH + 1;
   localparam int ROM_ADDR_W   = ATAN_IDX_W + 1;
   localparam int CORDIC_STEPS = 31;
   localparam int Q30_SHIFT    = 30 - FRAC_W;

   // pi/2 in q.23, rounded from q.30
   localparam logic signed [SAMPLE_W:0] HALF_PI_Q =
      25'((64'd1686629713 + (64'd1 << (Q30_SHIFT - 1))) >> Q30_SHIFT);

   // reciprocal divider: quotient bits and divisor / remainder width
   localparam int DIV_STEPS = 24;
   localparam int DIV_A_W   = 32;

   // output buffer depth
   localparam logic [1:0] SKID_DEPTH = 2'd2;

   typedef logic [ATAN_ENTRIES-1:0][SAMPLE_W-1:0] atan_rom_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  drive_gain;
      logic [BLEND_W-1:0] blend_m;      // already limited to unity
      logic [GAIN_W-1:0]  makeup_gain;
      logic               mute;
      logic               bypass;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;    // original sample for bypass
      logic                       neg;  // driven value is negative
      logic                       big;  // |driven| above one
      logic signed [SAMPLE_W:0]   hard; // hard clipped driven value
   } div_tag_type;

   typedef struct packed {
      logic                vld;
      logic [SAMPLE_W-1:0] y;
   } lane_res_type;

   function automatic longint cordic_angle(input int i);
      longint ang;
      case (i)
         0:  ang = 843314857;
         1:  ang = 497837916;
         2:  ang = 263043837;
         3:  ang = 133525159;
         4:  ang = 67021687;
         5:  ang = 33543516;
         6:  ang = 16775851;
         7:  ang = 8388437;
         8:  ang = 4194283;
         9:  ang = 2097149;
         10: ang = 1048576;
         11: ang = 524288;
         12: ang = 262144;
         13: ang = 131072;
         14: ang = 65536;
         15: ang = 32768;
         16: ang = 16384;
         17: ang = 8192;
         18: ang = 4096;
         19: ang = 2048;
         20: ang = 1024;
         21: ang = 512;
         22: ang = 256;
         23: ang = 128;
         24: ang = 64;
         25: ang = 32;
         26: ang = 16;
         27: ang = 8;
         28: ang = 4;
         29: ang = 2;
         30: ang = 1;
         default: ang = 0;
      endcase
      return ang;
   endfunction

   // vectoring cordic in q.30, evaluated once at elaboration
   function automatic atan_rom_type build_atan_rom();
      atan_rom_type rom;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      rom = '0;
      for (int k = 0; k < ATAN_ENTRIES; k++) begin
         x = longint'(1) <<< 30;
         y = longint'(k) <<< (30 - ATAN_IDX_W);
         z = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + cordic_angle(i);
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - cordic_angle(i);
            end
         end
         if (z < 0) begin
            z = 0;
         end
         rom[k] = SAMPLE_W'((z + (longint'(1) <<< (Q30_SHIFT - 1))) >>> Q30_SHIFT);
      end
      return rom;
   endfunction

   localparam atan_rom_type ATAN_ROM = build_atan_rom();

endpackage

`default_nettype wire

// ===== sv/ssh_recip_div.sv =====
// ----------------------------------------------------------------------------
// ssh_recip_div - pipelined reciprocal divider
// one restoring step per stage: q = round(2^46 / a), side data rides along
// ----------------------------------------------------------------------------
`default_nettype none

module ssh_recip_div import ssh_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_vld,
   input  wire logic [DIV_A_W-1:0] in_a,
   input  wire div_tag_type        in_tag,
   output logic                    out_vld,
   output logic [DIV_STEPS-1:0]    out_q,
   output logic [DIV_A_W-1:0]      out_a,
   output div_tag_type             out_tag
);

   // numerator is 2^46 + a/2; its top bits seed the remainder
   localparam logic [DIV_A_W-1:0] DIV_SEED = 32'd4194304;

   logic                 vld_ff [DIV_STEPS];
   logic [DIV_A_W-1:0]   rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS];
   logic [DIV_A_W-1:0]   a_ff   [DIV_STEPS];
   div_tag_type          tag_ff [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      logic                 vld_prev;
      logic [DIV_A_W-1:0]   rem_prev;
      logic [DIV_STEPS-1:0] q_prev;
      logic [DIV_A_W-1:0]   a_prev;
      div_tag_type          tag_prev;
      logic [DIV_A_W:0]     trial;
      logic                 ge;
      logic [DIV_A_W-1:0]   rem_in;
      logic [DIV_STEPS-1:0] q_in;

      if (i == 0) begin : g_first
         assign vld_prev = in_vld;
         assign rem_prev = DIV_SEED + DIV_A_W'(in_a[DIV_A_W-1:DIV_STEPS+1]);
         assign q_prev   = '0;
         assign a_prev   = in_a;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign vld_prev = vld_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign q_prev   = q_ff[i-1];
         assign a_prev   = a_ff[i-1];
         assign tag_prev = tag_ff[i-1];
      end

      // bring down the next numerator bit (a/2, msb first)
      assign trial  = {rem_prev, a_prev[DIV_STEPS-i]};
      assign ge     = trial >= {1'b0, a_prev};
      assign rem_in = ge ? DIV_A_W'(trial - {1'b0, a_prev}) : trial[DIV_A_W-1:0];
      assign q_in   = {q_prev[DIV_STEPS-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            q_ff[i]   <= q_in;
            a_ff[i]   <= a_prev;
            tag_ff[i] <= tag_prev;
         end
      end
   end

   assign out_vld = vld_ff[DIV_STEPS-1];
   assign out_q   = q_ff[DIV_STEPS-1];
   assign out_a   = a_ff[DIV_STEPS-1];
   assign out_tag = tag_ff[DIV_STEPS-1];

   // reciprocal of a value above one never exceeds one
   a_q_bound : assert property (@(posedge clock) disable iff (reset)
      out_vld && out_tag.big |-> out_q <= 24'd8388608)
      else $error("reciprocal above one");

endmodule

`default_nettype wire

// ===== sv/ssh_lane.sv =====
// ----------------------------------------------------------------------------
// ssh_lane - one channel of the waveshaper
// drive, soft/hard clip, blend, make-up gain, mute and bypass, fully pipelined
// ----------------------------------------------------------------------------
`default_nettype none

module ssh_lane import ssh_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire cfg_type                    cfg,
   input  wire logic                       in_vld,
   input  wire logic signed [SAMPLE_W-1:0] in_x,
   output lane_res_type                    res
);

   localparam int POST = 10;

   // front: input, drive product, rounding, magnitude
   logic                       v0_ff, v1_ff, v2_ff, v3_ff;
   logic signed [SAMPLE_W-1:0] x0_ff, x1_ff, x2_ff;
   logic signed [48:0]         p1_ff, p1_in, p1_rnd;
   logic signed [32:0]         d2_ff, d2_in;
   logic [DIV_A_W-1:0]         a3_ff, a3_in;
   div_tag_type                tag3_ff, tag3_in;

   // divider output
   logic                 dv_vld;
   logic [DIV_STEPS-1:0] dv_q;
   logic [DIV_A_W-1:0]   dv_a;
   div_tag_type          dv_tag;

   // back: lookup, interpolation, blend, make-up
   logic                       vld_ff  [POST];
   div_tag_type                side_ff [POST-1];
   logic [SAMPLE_W-1:0]        t_ff, t_in;
   logic [ROM_ADDR_W-1:0]      idx, hi_idx;
   logic [SAMPLE_W-1:0]        lo_ff, lo2_ff;
   logic signed [SAMPLE_W-1:0] diff_ff, diff_in;
   logic [14:0]                frac_ff;
   logic signed [39:0]         ip_ff, ip_in, ip_rnd;
   logic signed [SAMPLE_W:0]   lk_ff, lk_in, mag, soft_ff, soft_in;
   logic signed [SAMPLE_W:0]   soft5_ff, soft6_ff;
   logic signed [25:0]         dh_ff, dh_in, y_ff, y_in;
   logic signed [43:0]         bp_ff, bp_in, bp_rnd;
   logic signed [50:0]         mp_ff, mp_in, mp_rnd;
   logic signed [34:0]         z;
   logic [SAMPLE_W-1:0]        sat, out_ff, out_in;

   // ---------------- front ----------------
   assign p1_in  = 49'(x0_ff) * 49'($signed({1'b0, cfg.drive_gain}));
   assign p1_rnd = p1_ff + 49'sd32768;
   assign d2_in  = p1_rnd[48:16];

   assign a3_in = d2_ff[32] ? DIV_A_W'(-d2_ff) : d2_ff[DIV_A_W-1:0];

   always_comb begin
      tag3_in.x   = x2_ff;
      tag3_in.neg = d2_ff[32];
      tag3_in.big = a3_in > 32'd8388608;
      if (d2_ff > 33'sd8388608) begin
         tag3_in.hard = 25'sd8388608;
      end else if (d2_ff < -33'sd8388608) begin
         tag3_in.hard = -25'sd8388608;
      end else begin
         tag3_in.hard = d2_ff[SAMPLE_W:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_vld;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff   <= in_x;
         x1_ff   <= x0_ff;
         p1_ff   <= p1_in;
         x2_ff   <= x1_ff;
         d2_ff   <= d2_in;
         a3_ff   <= a3_in;
         tag3_ff <= tag3_in;
      end
   end

   ssh_recip_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (v3_ff),
      .in_a    (a3_ff),
      .in_tag  (tag3_ff),
      .out_vld (dv_vld),
      .out_q   (dv_q),
      .out_a   (dv_a),
      .out_tag (dv_tag)
   );

   // ---------------- back ----------------
   // above one the table is read at the reciprocal: atan(a) = pi/2 - atan(1/a)
   assign t_in = dv_tag.big ? dv_q : dv_a[SAMPLE_W-1:0];

   // table position t * depth, top bits index, low bits interpolate
   assign idx     = t_ff[SAMPLE_W-1:15];
   assign hi_idx  = idx[ATAN_IDX_W] ? idx : idx + 9'd1;
   assign diff_in = $signed(ATAN_ROM[hi_idx] - ATAN_ROM[idx]);

   assign ip_in  = 40'(diff_ff) * 40'($signed({1'b0, frac_ff}));
   assign ip_rnd = ip_ff + 40'sd16384;
   assign lk_in  = $signed({1'b0, lo2_ff}) + $signed(ip_rnd[39:15]);

   assign mag     = side_ff[3].big ? HALF_PI_Q - lk_ff : lk_ff;
   assign soft_in = side_ff[3].neg ? -mag : mag;

   assign dh_in  = 26'(side_ff[4].hard) - 26'(soft_ff);
   assign bp_in  = 44'(dh_ff) * 44'($signed({1'b0, cfg.blend_m}));
   assign bp_rnd = bp_ff + 44'sd32768;
   assign y_in   = 26'(soft6_ff) + 26'(bp_rnd[43:16]);

   assign mp_in  = 51'(y_ff) * 51'($signed({1'b0, cfg.makeup_gain}));
   assign mp_rnd = mp_ff + 51'sd32768;
   assign z      = mp_rnd[50:16];

   always_comb begin
      if (z > 35'sd8388607) begin
         sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else if (z < -35'sd8388608) begin
         sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat = z[SAMPLE_W-1:0];
      end
      if (cfg.bypass) begin
         out_in = side_ff[8].x;
      end else if (cfg.mute) begin
         out_in = '0;
      end else begin
         out_in = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < POST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= dv_vld;
         for (int k = 1; k < POST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= dv_tag;
         for (int k = 1; k < POST - 1; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         t_ff     <= t_in;
         lo_ff    <= ATAN_ROM[idx];
         diff_ff  <= diff_in;
         frac_ff  <= t_ff[14:0];
         ip_ff    <= ip_in;
         lo2_ff   <= lo_ff;
         lk_ff    <= lk_in;
         soft_ff  <= soft_in;
         dh_ff    <= dh_in;
         soft5_ff <= soft_ff;
         bp_ff    <= bp_in;
         soft6_ff <= soft5_ff;
         y_ff     <= y_in;
         mp_ff    <= mp_in;
         out_ff   <= out_in;
      end
   end

   assign res.vld = vld_ff[POST-1];
   assign res.y   = out_ff;

   // muted output is silent unless bypassed
   a_mute_zero : assert property (@(posedge clock) disable iff (reset)
      res.vld && cfg.mute && !cfg.bypass |-> res.y == '0)
      else $error("muted lane produced a nonzero sample");

endmodule

`default_nettype wire

// ===== sv/ssh_merge.sv =====
// ----------------------------------------------------------------------------
// ssh_merge - joins the two lane results into one stereo transfer
// two-entry output buffer decouples the pipeline from the receiver
// ----------------------------------------------------------------------------
`default_nettype none

module ssh_merge import ssh_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lane_res_type          left_res,
   input  wire lane_res_type          right_res,
   output logic                       pipe_en,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2*SAMPLE_W-1:0]      rsp_tdata
);

   logic [2*SAMPLE_W-1:0] ent_ff [2];
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  push, pop;

   assign pipe_en    = cnt_ff != SKID_DEPTH;
   assign push       = pipe_en && left_res.vld && right_res.vld;
   assign rsp_tvalid = cnt_ff != 2'd0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = ent_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= {right_res.y, left_res.y};
      end
   end

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SKID_DEPTH)
      else $error("output buffer overfilled");

   // lanes run in lockstep
   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      left_res.vld == right_res.vld)
      else $error("lane valids disagree");

endmodule

`default_nettype wire

// ===== sv/stereo_soft_hard_clip_waveshaper.sv =====
// ----------------------------------------------------------------------------
// stereo_soft_hard_clip_waveshaper - drive / blend stereo waveshaper
// arctangent soft clip and hard clip, blended, with make-up gain, mute, bypass
// ----------------------------------------------------------------------------
// usage
//   req_* carries one stereo pair per transfer, rsp_* one shaped pair back;
//   both are signed q1.23, left in the low half of tdata
//   csr_* writes drive gain, blend, make-up gain, mute and bypass; write only
//   while no pair is in flight, a write takes effect on the next pair
//   left and right run in two identical lanes; each lane is a 38-stage
//   pipeline whose length is set by the 24-step reciprocal divider used for
//   driven values above one; a merge stage packs both lanes into one result
//   a pair accepted on req passes the lane registers and then an output
//   buffer entry before it is offered on rsp
//   throughput: one pair per cycle, sustained while rsp_tready stays high
//   stall: a two-entry output buffer holds finished pairs; the pipeline
//   freezes (req_tready low) only when both entries are full, so a new pair
//   is still taken while one result waits
//   reset: synchronous; clears the pipeline, empties the output buffer and
//   loads unity drive, unity make-up, pure soft clip, mute and bypass off
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_soft_hard_clip_waveshaper import ssh_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [2*SAMPLE_W-1:0] req_tdata,   // right_sample, left_sample
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2*SAMPLE_W-1:0]      rsp_tdata,   // right_out, left_out
   // configuration writes
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   // configuration registers
   logic [GAIN_W-1:0]  drive_ff;
   logic [BLEND_W-1:0] blend_ff;
   logic [GAIN_W-1:0]  makeup_ff;
   logic               mute_ff;
   logic               bypass_ff;

   cfg_type      cfg;
   logic         pipe_en;
   lane_res_type left_res, right_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff  <= DRIVE_GAIN_RST;
         blend_ff  <= BLEND_RST;
         makeup_ff <= MAKEUP_GAIN_RST;
         mute_ff   <= 1'b0;
         bypass_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DRIVE_GAIN:   drive_ff  <= csr_wr_data;
            REG_BLEND_AMOUNT: blend_ff  <= csr_wr_data[BLEND_W-1:0];
            REG_MAKEUP_GAIN:  makeup_ff <= csr_wr_data;
            REG_MUTE_ENABLE:  mute_ff   <= csr_wr_data[0];
            REG_BYPASS:       bypass_ff <= csr_wr_data[0];
            default: ;        // unknown index: write dropped
         endcase
      end
   end

   // blend above unity acts as full hard clip
   assign cfg.drive_gain  = drive_ff;
   assign cfg.blend_m     = (blend_ff > BLEND_UNITY) ? BLEND_UNITY : blend_ff;
   assign cfg.makeup_gain = makeup_ff;
   assign cfg.mute        = mute_ff;
   assign cfg.bypass      = bypass_ff;   // bypass wins over mute in the lanes

   // whole pipeline advances together; accept whenever it advances
   assign req_tready = pipe_en;

   ssh_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .en     (pipe_en),
      .cfg    (cfg),
      .in_vld (req_tvalid),
      .in_x   (req_tdata[SAMPLE_W-1:0]),
      .res    (left_res)
   );

   ssh_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .en     (pipe_en),
      .cfg    (cfg),
      .in_vld (req_tvalid),
      .in_x   (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .res    (right_res)
   );

   // pack both lanes and buffer toward the receiver
   ssh_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .left_res   (left_res),
      .right_res  (right_res),
      .pipe_en    (pipe_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
